/* rtl/bpps_pkg.sv */
// ----------------------------------------------------------------------------
// bpps_pkg: shared types and constants of the point-light shader
// Item and result structs, light record, command codes and the
// saturating helpers used by the sequencer.
// ----------------------------------------------------------------------------
package bpps_pkg;

    // Item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SHADE = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_AW = 3;
    localparam logic [CFG_AW-1:0] CFG_LIGHT_COUNT   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_AMBIENT_TERM  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_SPECULAR_GAIN = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SHININESS     = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_EYE_Z         = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [3:0]         RST_LIGHT_COUNT   = 4'd0;
    localparam logic [15:0]        RST_AMBIENT_TERM  = 16'd3277;
    localparam logic [15:0]        RST_SPECULAR_GAIN = 16'd52016;
    localparam logic [7:0]         RST_SHININESS     = 8'd150;
    localparam logic signed [31:0] RST_EYE_Z         = 32'sd327680;

    // Product cap 2^48 and unit value 1.0 in Q16.16.
    localparam logic [48:0] CAP_VAL = 49'h1_0000_0000_0000;
    localparam logic [16:0] ONE_Q16 = 17'h1_0000;

    typedef struct packed {
        logic               kind;
        logic [2:0]         slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        color_r;
        logic [31:0]        color_g;
        logic [31:0]        color_b;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
    } t_item;

    typedef struct packed {
        logic [31:0] out_r;
        logic [31:0] out_g;
        logic [31:0] out_b;
    } t_result;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        int_r;
        logic [31:0]        int_g;
        logic [31:0]        int_b;
    } t_light;

    // (p >> 16) limited to 2^48.
    function automatic logic [48:0] sat_shr16(input logic [127:0] p);
        logic over;
        over = (|p[127:65]) || (p[64] && (|p[63:16]));
        return over ? CAP_VAL : p[64:16];
    endfunction

    // Sum of two values at most 2^48, limited to 2^48.
    function automatic logic [48:0] sat_add49(input logic [48:0] a, input logic [48:0] b);
        logic [49:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, CAP_VAL}) ? CAP_VAL : s[48:0];
    endfunction

    // 64-bit sum that sticks at all ones.
    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // Final channel value: (acc + ambient) * 255, limited to 32 bits.
    function automatic logic [31:0] out_scale(input logic [48:0] acc, input logic [15:0] amb);
        logic [48:0] x;
        logic [56:0] t;
        x = sat_add49(acc, {33'b0, amb});
        t = {x, 8'b0} - {8'b0, x};
        return (|t[56:32]) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

endpackage

/* rtl/bpps_mul.sv */
// ----------------------------------------------------------------------------
// bpps_mul: shared 64 x 64 multiplier
// Four 32 x 32 partial products, one per cycle, summed into a 128-bit
// accumulator; o_done pulses when o_p holds the full product.
// ----------------------------------------------------------------------------
module bpps_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_go,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic [127:0] o_p,
    output logic         o_done
);

    logic         r_busy;
    logic [2:0]   r_k;
    logic         r_pv;
    logic [1:0]   r_ps;
    logic [63:0]  r_pp;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic         r_done;
    logic [31:0]  w_pa;
    logic [31:0]  w_pb;
    logic [6:0]   w_sh;

    assign w_pa = r_k[1] ? r_a[63:32] : r_a[31:0];
    assign w_pb = r_k[0] ? r_b[63:32] : r_b[31:0];
    assign w_sh = {r_ps[1] & r_ps[0], r_ps[1] ^ r_ps[0], 5'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= '0;
            r_pv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_k    <= '0;
                r_pv   <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_k != 3'd4) begin
                    r_pp <= w_pa * w_pb;
                    r_ps <= r_k[1:0];
                    r_pv <= 1'b1;
                    r_k  <= r_k + 3'd1;
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_pv) begin
                    r_acc <= r_acc + ({64'b0, r_pp} << w_sh);
                end
                if (r_k == 3'd4 && r_pv) begin
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_p    = r_acc;
    assign o_done = r_done;

endmodule

/* rtl/bpps_div.sv */
// ----------------------------------------------------------------------------
// bpps_div: 48-bit restoring divider
// One quotient bit per cycle; the divisor is never zero when started.
// ----------------------------------------------------------------------------
module bpps_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [47:0] i_num,
    input  logic [47:0] i_den,
    output logic [47:0] o_q,
    output logic        o_done
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [47:0] r_rem;
    logic [47:0] r_q;
    logic [47:0] r_den;
    logic        r_done;
    logic [48:0] w_trial;
    logic        w_ge;
    logic [48:0] w_diff;

    assign w_trial = {r_rem, r_q[47]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
                r_cnt  <= 6'd47;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[47:0] : w_trial[47:0];
                r_q   <= {r_q[46:0], w_ge};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_q    = r_q;
    assign o_done = r_done;

endmodule

/* rtl/bpps_sqrt.sv */
// ----------------------------------------------------------------------------
// bpps_sqrt: integer square root of a 62-bit value
// Digit-by-digit method, one result bit per cycle, exact floor.
// ----------------------------------------------------------------------------
module bpps_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [61:0] i_x,
    output logic [30:0] o_r,
    output logic        o_done
);

    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [61:0] r_x;
    logic [61:0] r_r;
    logic [61:0] r_bit;
    logic        r_done;
    logic [62:0] w_sum;
    logic        w_ge;

    assign w_sum = {1'b0, r_r} + {1'b0, r_bit};
    assign w_ge  = {1'b0, r_x} >= w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_x    <= i_x;
                r_r    <= '0;
                r_bit  <= 62'(1) << 60;
                r_cnt  <= 5'd30;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) begin
                    r_x <= r_x - w_sum[61:0];
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_r    = r_r[30:0];
    assign o_done = r_done;

endmodule

/* rtl/blinn_phong_point_light_shader_top.sv */
// ----------------------------------------------------------------------------
// blinn_phong_point_light_shader_top: fixed-point Blinn-Phong shader
// A sequencer runs every step of the shading math through one shared
// multiplier, one divider and one square-root unit.
//
//   Channel   Direction  Handshake                 Payload
//   -------   ---------  ------------------------  -----------------------
//   item      in         start high, busy low      i_item (t_item)
//   result    out        o_valid, one cycle         o_result (t_result)
//   config    in         i_cfg_we                   i_cfg_addr, i_cfg_data
//
// A load item is stored when it is taken (a slot past MAX_LIGHTS is
// dropped) and busy stays low. A shade item keeps busy high until its
// result is shown, over the normal and view vectors and each light that
// is not skipped; the divider and the square-root unit take most of that time.
// Reset is synchronous and active low; the light store is not cleared.
// The result is shown for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module blinn_phong_point_light_shader_top #(
    parameter int MAX_LIGHTS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  bpps_pkg::t_item                    i_item,
    output logic                               o_valid,
    output bpps_pkg::t_result                  o_result,
    input  logic                               i_cfg_we,
    input  logic [bpps_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [31:0]                        i_cfg_data
);

    // Index width of the light store; a single slot still gets one bit.
    localparam int IW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam logic [6:0] MAXL = 7'(MAX_LIGHTS);

    typedef enum logic [4:0] {
        S_IDLE, S_NMAG, S_NSQ, S_NSQW, S_NRT, S_NRTW, S_NDV, S_NDVW, S_NEND,
        S_LSTART, S_LRD, S_R2SQ, S_R2SQW, S_R2END, S_DMUL, S_DMULW, S_DEND,
        S_PCHK, S_PRW, S_PB, S_PBW, S_CDIV, S_CDIVW, S_CMUL, S_CMULW, S_FIN
    } t_state;

    // Which vector the normalize sequence is working on.
    typedef enum logic [1:0] {NS_N, NS_V, NS_L, NS_H} t_nsel;

    t_state r_state;
    t_nsel  r_nsel;

    // Configuration registers.
    logic [3:0]         r_light_count;
    logic [15:0]        r_ambient;
    logic [15:0]        r_spec_gain;
    logic [7:0]         r_shininess;
    logic signed [31:0] r_eye_z;

    // Light store and its registered read port.
    bpps_pkg::t_light r_mem [MAX_LIGHTS];
    bpps_pkg::t_light r_rd;

    // Fragment and working values.
    logic signed [31:0] r_p    [3];
    logic [31:0]        r_kd   [3];
    logic signed [33:0] r_vec  [3];
    logic [29:0]        r_a    [3];
    logic signed [17:0] r_unit [3];
    logic signed [17:0] r_n    [3];
    logic signed [17:0] r_v    [3];
    logic signed [17:0] r_lu   [3];
    logic [48:0]        r_acc  [3];
    logic [61:0]        r_sum;
    logic [30:0]        r_len;
    logic [1:0]         r_k;
    logic [63:0]        r_r2;
    logic [47:0]        r_r2d;
    logic signed [34:0] r_dot;
    logic [16:0]        r_nl;
    logic [16:0]        r_pr;
    logic [16:0]        r_pb;
    logic [7:0]         r_pe;
    logic [47:0]        r_ir2;
    logic [48:0]        r_sd;
    logic [48:0]        r_ss;
    logic [1:0]         r_c;
    logic [1:0]         r_op;
    logic [6:0]         r_li;
    logic [6:0]         r_cnt;
    logic               r_valid;
    bpps_pkg::t_result  r_result;

    // Shared unit requests.
    logic         r_mgo;
    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic [127:0] w_mp;
    logic         w_mdone;
    logic         r_dgo;
    logic [47:0]  r_dn;
    logic [47:0]  r_dd;
    logic [47:0]  w_dq;
    logic         w_ddone;
    logic         r_sgo;
    logic [61:0]  r_sx;
    logic [30:0]  w_sr;
    logic         w_sdone;

    logic               w_accept;
    logic [6:0]         w_slot;
    logic [32:0]        w_mag [3];
    logic [32:0]        w_or;
    logic [1:0]         w_sh;
    logic signed [33:0] w_l   [3];
    logic               w_lzero;
    logic [16:0]        w_dres;
    logic [33:0]        w_dp;
    logic               w_dneg;
    logic [48:0]        w_sat;
    logic [31:0]        w_int [3];
    logic [33:0]        w_neg [3];

    bpps_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_mgo),
        .i_a    (r_ma),
        .i_b    (r_mb),
        .o_p    (w_mp),
        .o_done (w_mdone)
    );

    bpps_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_dgo),
        .i_num  (r_dn),
        .i_den  (r_dd),
        .o_q    (w_dq),
        .o_done (w_ddone)
    );

    bpps_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (r_sgo),
        .i_x    (r_sx),
        .o_r    (w_sr),
        .o_done (w_sdone)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_slot   = {4'b0, i_item.slot};

    // Magnitudes of the vector being normalized, and the common right shift
    // that brings every component below 2^30.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_neg[i] = -r_vec[i];
            w_mag[i] = r_vec[i][33] ? w_neg[i][32:0] : r_vec[i][32:0];
        end
        w_or = w_mag[0] | w_mag[1] | w_mag[2];
        if (w_or[32]) begin
            w_sh = 2'd3;
        end else if (w_or[31]) begin
            w_sh = 2'd2;
        end else if (w_or[30]) begin
            w_sh = 2'd1;
        end else begin
            w_sh = 2'd0;
        end
    end

    // Light vector of the light just read from the store.
    assign w_l[0]  = 34'(r_rd.pos_x) - 34'(r_p[0]);
    assign w_l[1]  = 34'(r_rd.pos_y) - 34'(r_p[1]);
    assign w_l[2]  = 34'(r_rd.pos_z) - 34'(r_p[2]);
    assign w_lzero = (w_l[0] == '0) && (w_l[1] == '0) && (w_l[2] == '0);
    assign w_int[0] = r_rd.int_r;
    assign w_int[1] = r_rd.int_g;
    assign w_int[2] = r_rd.int_b;

    // Clamped dot product: zero when not positive, else (s >> 16) up to 1.0.
    always_comb begin
        if (r_dot <= 0) begin
            w_dres = '0;
        end else if (r_dot[34:16] > 19'(bpps_pkg::ONE_Q16)) begin
            w_dres = bpps_pkg::ONE_Q16;
        end else begin
            w_dres = r_dot[32:16];
        end
    end

    assign w_dp   = w_mp[33:0];
    assign w_dneg = r_n[r_k][17] ^ r_unit[r_k][17];
    assign w_sat  = bpps_pkg::sat_shr16(w_mp);

    // Light store: written by load items, read one slot at a time.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_item.kind == bpps_pkg::KIND_LOAD && w_slot < MAXL) begin
            r_mem[w_slot[IW-1:0]] <= '{i_item.pos_x, i_item.pos_y, i_item.pos_z,
                                        i_item.color_r, i_item.color_g, i_item.color_b};
        end
        r_rd <= r_mem[r_li[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_nsel        <= NS_N;
            r_light_count <= bpps_pkg::RST_LIGHT_COUNT;
            r_ambient     <= bpps_pkg::RST_AMBIENT_TERM;
            r_spec_gain   <= bpps_pkg::RST_SPECULAR_GAIN;
            r_shininess   <= bpps_pkg::RST_SHININESS;
            r_eye_z       <= bpps_pkg::RST_EYE_Z;
            r_valid       <= 1'b0;
            r_mgo         <= 1'b0;
            r_dgo         <= 1'b0;
            r_sgo         <= 1'b0;
            r_k           <= '0;
            r_c           <= '0;
            r_op          <= '0;
            r_li          <= '0;
            r_cnt         <= '0;
        end else begin
            r_valid <= 1'b0;
            r_mgo   <= 1'b0;
            r_dgo   <= 1'b0;
            r_sgo   <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    bpps_pkg::CFG_LIGHT_COUNT:   r_light_count <= i_cfg_data[3:0];
                    bpps_pkg::CFG_AMBIENT_TERM:  r_ambient     <= i_cfg_data[15:0];
                    bpps_pkg::CFG_SPECULAR_GAIN: r_spec_gain   <= i_cfg_data[15:0];
                    bpps_pkg::CFG_SHININESS:     r_shininess   <= i_cfg_data[7:0];
                    bpps_pkg::CFG_EYE_Z:         r_eye_z       <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_item.kind == bpps_pkg::KIND_SHADE) begin
                        r_p[0]   <= i_item.pos_x;
                        r_p[1]   <= i_item.pos_y;
                        r_p[2]   <= i_item.pos_z;
                        r_kd[0]  <= i_item.color_r;
                        r_kd[1]  <= i_item.color_g;
                        r_kd[2]  <= i_item.color_b;
                        r_vec[0] <= 34'(i_item.normal_x);
                        r_vec[1] <= 34'(i_item.normal_y);
                        r_vec[2] <= 34'(i_item.normal_z);
                        for (int i = 0; i < 3; i++) begin
                            r_acc[i] <= '0;
                        end
                        r_cnt   <= ({3'b0, r_light_count} > MAXL) ? MAXL
                                                                  : {3'b0, r_light_count};
                        r_nsel  <= NS_N;
                        r_state <= S_NMAG;
                    end
                end

                // Normalize r_vec into r_unit.
                S_NMAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_a[i] <= 30'(w_mag[i] >> w_sh);
                    end
                    r_sum   <= '0;
                    r_k     <= '0;
                    r_state <= S_NSQ;
                end
                S_NSQ: begin
                    r_ma    <= {34'b0, r_a[r_k]};
                    r_mb    <= {34'b0, r_a[r_k]};
                    r_mgo   <= 1'b1;
                    r_state <= S_NSQW;
                end
                S_NSQW: begin
                    if (w_mdone) begin
                        r_sum <= r_sum + w_mp[61:0];
                        if (r_k == 2'd2) begin
                            r_state <= S_NRT;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_NSQ;
                        end
                    end
                end
                S_NRT: begin
                    r_sx    <= r_sum;
                    r_sgo   <= 1'b1;
                    r_state <= S_NRTW;
                end
                S_NRTW: begin
                    if (w_sdone) begin
                        r_len   <= w_sr;
                        r_k     <= '0;
                        r_state <= S_NDV;
                    end
                end
                S_NDV: begin
                    // A zero vector normalizes to zero.
                    if (r_len == '0) begin
                        r_unit[r_k] <= '0;
                        if (r_k == 2'd2) begin
                            r_state <= S_NEND;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end else begin
                        r_dn    <= {2'b0, r_a[r_k], 16'b0};
                        r_dd    <= {17'b0, r_len};
                        r_dgo   <= 1'b1;
                        r_state <= S_NDVW;
                    end
                end
                S_NDVW: begin
                    if (w_ddone) begin
                        r_unit[r_k] <= r_vec[r_k][33] ? -{1'b0, w_dq[16:0]}
                                                      : {1'b0, w_dq[16:0]};
                        if (r_k == 2'd2) begin
                            r_state <= S_NEND;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_NDV;
                        end
                    end
                end
                S_NEND: begin
                    unique case (r_nsel)
                        NS_N: begin
                            r_n      <= r_unit;
                            r_vec[0] <= -34'(r_p[0]);
                            r_vec[1] <= -34'(r_p[1]);
                            r_vec[2] <= 34'(r_eye_z) - 34'(r_p[2]);
                            r_nsel   <= NS_V;
                            r_state  <= S_NMAG;
                        end
                        NS_V: begin
                            r_v     <= r_unit;
                            r_li    <= '0;
                            r_state <= S_LSTART;
                        end
                        NS_L: begin
                            r_lu    <= r_unit;
                            r_dot   <= '0;
                            r_k     <= '0;
                            r_state <= S_DMUL;
                        end
                        default: begin
                            r_dot   <= '0;
                            r_k     <= '0;
                            r_state <= S_DMUL;
                        end
                    endcase
                end

                // Per-light loop.
                S_LSTART: begin
                    r_state <= (r_li >= r_cnt) ? S_FIN : S_LRD;
                end
                S_LRD: begin
                    // A light sitting exactly at the fragment adds nothing.
                    if (w_lzero) begin
                        r_li    <= r_li + 7'd1;
                        r_state <= S_LSTART;
                    end else begin
                        r_vec   <= w_l;
                        r_r2    <= '0;
                        r_k     <= '0;
                        r_state <= S_R2SQ;
                    end
                end
                S_R2SQ: begin
                    if (w_mag[r_k][32]) begin
                        r_r2 <= '1;
                        if (r_k == 2'd2) begin
                            r_state <= S_R2END;
                        end else begin
                            r_k <= r_k + 2'd1;
                        end
                    end else begin
                        r_ma    <= {31'b0, w_mag[r_k]};
                        r_mb    <= {31'b0, w_mag[r_k]};
                        r_mgo   <= 1'b1;
                        r_state <= S_R2SQW;
                    end
                end
                S_R2SQW: begin
                    if (w_mdone) begin
                        r_r2 <= bpps_pkg::sat_add64(r_r2, w_mp[63:0]);
                        if (r_k == 2'd2) begin
                            r_state <= S_R2END;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_R2SQ;
                        end
                    end
                end
                S_R2END: begin
                    r_r2d   <= (r_r2[63:16] == '0) ? 48'd1 : r_r2[63:16];
                    r_nsel  <= NS_L;
                    r_state <= S_NMAG;
                end

                // Dot product of the normal with the unit vector just made.
                S_DMUL: begin
                    r_ma    <= {47'b0, r_n[r_k][17] ? -r_n[r_k][16:0] : r_n[r_k][16:0]};
                    r_mb    <= {47'b0, r_unit[r_k][17] ? -r_unit[r_k][16:0]
                                                       : r_unit[r_k][16:0]};
                    r_mgo   <= 1'b1;
                    r_state <= S_DMULW;
                end
                S_DMULW: begin
                    if (w_mdone) begin
                        r_dot <= w_dneg ? r_dot - 35'(w_dp) : r_dot + 35'(w_dp);
                        if (r_k == 2'd2) begin
                            r_state <= S_DEND;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_DMUL;
                        end
                    end
                end
                S_DEND: begin
                    if (r_nsel == NS_L) begin
                        r_nl <= w_dres;
                        for (int i = 0; i < 3; i++) begin
                            r_vec[i] <= 34'(r_v[i]) + 34'(r_lu[i]);
                        end
                        r_nsel  <= NS_H;
                        r_state <= S_NMAG;
                    end else begin
                        r_pr    <= bpps_pkg::ONE_Q16;
                        r_pb    <= w_dres;
                        r_pe    <= r_shininess;
                        r_state <= S_PCHK;
                    end
                end

                // n.h raised to the shininess, low exponent bit first.
                S_PCHK: begin
                    if (r_pe == '0) begin
                        r_c     <= '0;
                        r_state <= S_CDIV;
                    end else if (r_pe[0]) begin
                        r_ma    <= {47'b0, r_pr};
                        r_mb    <= {47'b0, r_pb};
                        r_mgo   <= 1'b1;
                        r_state <= S_PRW;
                    end else begin
                        r_state <= S_PB;
                    end
                end
                S_PRW: begin
                    if (w_mdone) begin
                        r_pr    <= w_mp[32:16];
                        r_state <= S_PB;
                    end
                end
                S_PB: begin
                    r_ma    <= {47'b0, r_pb};
                    r_mb    <= {47'b0, r_pb};
                    r_mgo   <= 1'b1;
                    r_state <= S_PBW;
                end
                S_PBW: begin
                    if (w_mdone) begin
                        r_pb    <= w_mp[32:16];
                        r_pe    <= r_pe >> 1;
                        r_state <= S_PCHK;
                    end
                end

                // Per channel: intensity over r^2, then the four products.
                S_CDIV: begin
                    r_dn    <= {w_int[r_c], 16'b0};
                    r_dd    <= r_r2d;
                    r_dgo   <= 1'b1;
                    r_state <= S_CDIVW;
                end
                S_CDIVW: begin
                    if (w_ddone) begin
                        r_ir2   <= w_dq;
                        r_op    <= '0;
                        r_state <= S_CMUL;
                    end
                end
                S_CMUL: begin
                    case (r_op)
                        2'd0: begin
                            r_ma <= {16'b0, r_ir2};
                            r_mb <= {47'b0, r_nl};
                        end
                        2'd1: begin
                            r_ma <= {16'b0, r_ir2};
                            r_mb <= {47'b0, r_pr};
                        end
                        2'd2: begin
                            r_ma <= {32'b0, r_kd[r_c]};
                            r_mb <= {15'b0, r_sd};
                        end
                        default: begin
                            r_ma <= {48'b0, r_spec_gain};
                            r_mb <= {15'b0, r_ss};
                        end
                    endcase
                    r_mgo   <= 1'b1;
                    r_state <= S_CMULW;
                end
                S_CMULW: begin
                    if (w_mdone) begin
                        case (r_op)
                            2'd0:    r_sd <= w_sat;
                            2'd1:    r_ss <= w_sat;
                            default: r_acc[r_c] <= bpps_pkg::sat_add49(r_acc[r_c], w_sat);
                        endcase
                        if (r_op != 2'd3) begin
                            r_op    <= r_op + 2'd1;
                            r_state <= S_CMUL;
                        end else if (r_c == 2'd2) begin
                            r_li    <= r_li + 7'd1;
                            r_state <= S_LSTART;
                        end else begin
                            r_c     <= r_c + 2'd1;
                            r_state <= S_CDIV;
                        end
                    end
                end

                S_FIN: begin
                    r_result.out_r <= bpps_pkg::out_scale(r_acc[0], r_ambient);
                    r_result.out_g <= bpps_pkg::out_scale(r_acc[1], r_ambient);
                    r_result.out_b <= bpps_pkg::out_scale(r_acc[2], r_ambient);
                    r_valid        <= 1'b1;
                    r_state        <= S_IDLE;
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // The light loop never runs past the number of lights in use.
    a_li_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LRD) |-> (r_li < r_cnt))
        else $error("light index past light count");

    // A result is shown only at the end of a shade item, and the block is
    // free again the cycle it is shown.
    a_valid_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_FIN) && !busy)
        else $error("result strobe outside the end of a shade item");

    // An accepted shade item makes the block busy on the next cycle.
    a_shade_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.kind == bpps_pkg::KIND_SHADE) |=> busy)
        else $error("shade item accepted without going busy");

    // Only one shared unit is started at a time.
    a_one_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_mgo, r_dgo, r_sgo}))
        else $error("two shared units started together");

endmodule
